// ----- rtl/group_reverse_stream_macros.svh -----
// Assertion macros shared by the group reverse stream RTL.
`ifndef GROUP_REVERSE_STREAM_MACROS_SVH
`define GROUP_REVERSE_STREAM_MACROS_SVH

`ifndef SYNTH
`define GRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("group reverse stream: implication check failed");
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("group reverse stream: next-cycle check failed");
`else
`define GRS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/grs_pkg.sv -----
// Types and constants of the group reverse stream block.
package grs_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = 7'd4;

    typedef enum logic [0:0] {
        ST_FILL,
        ST_DRAIN
    } grs_state_t;

endpackage

// ----- rtl/group_reverse_stream.sv -----
// Group reverse stream: reverses a list stream in groups of a configurable size.
// Output: after the request that completes a group is accepted, its first result
// passes through the read register rd_data_reg and the output register m_data_reg,
// then one result per cycle follows while m_tready is high, from the group memory.
// Requests are taken only while filling; no request is taken while draining.
// Reset: synchronous active-low aresetn empties the group and sets the size to 4.
`include "group_reverse_stream_macros.svh"

module group_reverse_stream #(
    parameter int MAX_GROUP = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [grs_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [grs_pkg::DATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic                         s_tlast,   // list_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [grs_pkg::DATA_W-1:0]   m_tdata,   // [31:0] out_value
    output logic                         m_tlast,   // run_last
    output logic                         m_tuser    // [0] list_done
);

    import grs_pkg::*;

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic [DATA_W-1:0] mem [MAX_GROUP];

    grs_state_t        state_reg, state_next;
    logic [CFG_W-1:0]  group_size_reg;
    logic [CW-1:0]     fill_count_reg, fill_count_next;
    logic [CW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic              list_end_reg, list_end_next;
    logic              rd_valid_reg;
    logic              rd_last_reg, rd_done_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic              m_last_reg, m_done_reg;

    logic [CFG_W-1:0]  eff_size;
    logic [CW-1:0]     push_count;
    logic              flush;
    logic              s_accept;
    logic              out_load;
    logic              rd_issue;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;

    always_comb begin
        if (group_size_reg == '0) begin
            eff_size = CFG_W'(1);
        end else if (32'(group_size_reg) > MAX_GROUP) begin
            eff_size = CFG_W'(MAX_GROUP);
        end else begin
            eff_size = group_size_reg;
        end
    end

    assign push_count = fill_count_reg + CW'(1);
    assign flush      = (32'(push_count) >= 32'(eff_size)) || s_tlast;
    assign s_accept   = s_tvalid && s_tready;
    assign out_load   = rd_valid_reg && (!m_valid_reg || m_tready);
    assign rd_addr    = AW'(rd_ptr_reg - CW'(1));
    assign wr_addr    = AW'(fill_count_reg);

    always_comb begin
        s_tready = 1'b0;
        rd_issue = 1'b0;
        unique case (state_reg)
            ST_FILL: begin
                s_tready = 1'b1;
            end
            ST_DRAIN: begin
                rd_issue = (rd_ptr_reg != '0) && (!rd_valid_reg || out_load);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        rd_ptr_next     = rd_ptr_reg;
        list_end_next   = list_end_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (s_accept) begin
                    if (flush) begin
                        fill_count_next = '0;
                        rd_ptr_next     = push_count;
                        list_end_next   = s_tlast;
                        state_next      = ST_DRAIN;
                    end else begin
                        fill_count_next = push_count;
                    end
                end
            end
            ST_DRAIN: begin
                if (rd_issue) begin
                    rd_ptr_next = rd_ptr_reg - CW'(1);
                    if (rd_ptr_reg == CW'(1)) begin
                        state_next = ST_FILL;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mem[wr_addr] <= s_tdata;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            group_size_reg <= GROUP_SIZE_RESET;
            fill_count_reg <= '0;
            rd_ptr_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rd_ptr_reg     <= rd_ptr_next;
            if (cfg_wr_en) begin
                group_size_reg <= cfg_wr_data;
            end
            if (rd_issue) begin
                rd_valid_reg <= 1'b1;
            end else if (out_load) begin
                rd_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        list_end_reg <= list_end_next;
        if (rd_issue) begin
            rd_last_reg <= (rd_ptr_reg == CW'(1));
            rd_done_reg <= (rd_ptr_reg == CW'(1)) && list_end_reg;
        end
        if (out_load) begin
            m_data_reg <= rd_data_reg;
            m_last_reg <= rd_last_reg;
            m_done_reg <= rd_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

    `GRS_ASSERT_IMPL(a_fill_in_range, aclk, aresetn, s_tready, 32'(fill_count_reg) < MAX_GROUP)
    `GRS_ASSERT_IMPL(a_drain_empty, aclk, aresetn, state_reg == ST_DRAIN, fill_count_reg == '0)
    `GRS_ASSERT_NEXT(a_read_lands, aclk, aresetn, rd_issue, rd_valid_reg)
    `GRS_ASSERT_IMPL(a_done_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)

endmodule
